@@ rtl/tkos_pkg.sv @@
// Shared types, configuration indexes and the row ordering function
// for the top-N selector. No dependencies.
package tkos_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned TagW    = 16;
  localparam int unsigned CntW    = 7;
  localparam int unsigned NKeysW  = 2;
  localparam int unsigned DirW    = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned DataW   = 3 * KeyW + TagW;

  localparam logic [CfgIdxW-1:0] CFG_KEEP_COUNT     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_COUNT     = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEYS_IN_USE    = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_DIRECTIONS = 8'd3;

  typedef struct packed {
    logic signed [KeyW-1:0] key_first;
    logic signed [KeyW-1:0] key_second;
    logic signed [KeyW-1:0] key_third;
    logic [TagW-1:0]        tag;
  } row_t;

  typedef struct packed {
    logic [NKeysW-1:0] keys_in_use;
    logic [DirW-1:0]   key_directions;
  } cmp_cfg_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SKIP,
    ST_EMIT
  } state_e;

  // true when row a sorts strictly before row b
  function automatic logic row_better(row_t a, row_t b, cmp_cfg_t cfg);
    logic signed [KeyW-1:0] x [3];
    logic signed [KeyW-1:0] y [3];
    logic res;
    logic done;
    x[0] = a.key_first;
    x[1] = a.key_second;
    x[2] = a.key_third;
    y[0] = b.key_first;
    y[1] = b.key_second;
    y[2] = b.key_third;
    res  = 1'b0;
    done = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!done && (NKeysW'(k) < cfg.keys_in_use) && (x[k] != y[k])) begin
        res  = cfg.key_directions[k] ? (x[k] > y[k]) : (x[k] < y[k]);
        done = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/tkos_cell.sv @@
// One slot of the sorted insertion chain: holds a row and its valid bit.
// Depends on tkos_pkg.
module tkos_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned LIMW = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tkos_pkg::cell_ctrl_t ctrl_i,
  input  tkos_pkg::cmp_cfg_t cfg_i,
  input  logic [LIMW-1:0]    lim_i,
  input  tkos_pkg::row_t     in_row_i,
  input  logic               reject_i,
  input  logic               prev_take_i,
  input  tkos_pkg::row_t     prev_row_i,
  input  logic               prev_valid_i,
  input  tkos_pkg::row_t     next_row_i,
  input  logic               next_valid_i,
  output tkos_pkg::row_t     row_o,
  output logic               valid_o,
  output logic               take_o,
  output logic               miss_o
);
  import tkos_pkg::*;

  row_t row_q, row_d;
  logic valid_q, valid_d;
  logic in_range;
  logic hit;
  logic last_slot;

  assign in_range  = lim_i > LIMW'(IDX);
  assign last_slot = lim_i == LIMW'(IDX + 1);
  assign valid_o   = valid_q && in_range;
  assign hit       = !valid_o || row_better(in_row_i, row_q, cfg_i);
  assign miss_o    = last_slot && valid_o && !hit;
  assign take_o    = in_range && !reject_i && (prev_take_i || hit);
  assign row_o     = row_q;

  always_comb begin
    row_d   = row_q;
    valid_d = valid_q;
    if (ctrl_i.load) begin
      valid_d = valid_o;
      if (prev_take_i) begin
        row_d   = prev_row_i;
        valid_d = prev_valid_i && in_range;
      end else if (take_o) begin
        row_d   = in_row_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      row_d   = next_row_i;
      valid_d = next_valid_i && in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

endmodule

@@ rtl/top_n_with_offset_selector.sv @@
// Throughput: one row per cycle while loading. After the last row, the chain shifts out the
// skip_count leading rows, then gives one result per cycle while m_axis_tready does not stall it.
// A run with nothing at the output positions gives one empty result instead.
// Reset clears the valid bits, the control state and the output valid flag at once;
// configuration returns to keep 10, skip 0, one key, all ascending. No clearing pass.
module top_n_with_offset_selector #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // key_first, key_second, key_third, row_tag
  input  logic [tkos_pkg::DataW-1:0]  s_axis_tdata,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_tag, out_key_first, out_key_second, out_key_third
  output logic [tkos_pkg::DataW-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast,
  // empty_set
  output logic                        m_axis_tuser,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tkos_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tkos_pkg::CntW-1:0]   cfg_data_i
);
  import tkos_pkg::*;

  localparam int unsigned LIMW = $clog2(CAPACITY + 1);
  localparam int unsigned SUMW = 9;

  logic [CntW-1:0]   keep_q, skip_q;
  logic [NKeysW-1:0] nkeys_q;
  logic [DirW-1:0]   dirs_q;
  cmp_cfg_t          cmp_cfg;
  logic [SUMW-1:0]   lim_sum;
  logic [LIMW-1:0]   lim;

  state_e          state_q, state_d;
  logic [CntW-1:0] skip_cnt_q, skip_cnt_d;
  cell_ctrl_t      ctrl;
  row_t            in_row;
  logic            in_acc;
  logic            out_take;

  row_t rows   [CAPACITY];
  logic valids [CAPACITY];
  logic takes  [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] miss_vec;
  logic reject;
  logic v1;

  row_t out_row_q, out_row_d;
  logic out_valid_q, out_valid_d;
  logic out_last_q, out_last_d;
  logic out_empty_q, out_empty_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= CntW'(10);
      skip_q  <= '0;
      nkeys_q <= NKeysW'(1);
      dirs_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEEP_COUNT:     keep_q  <= cfg_data_i;
        CFG_SKIP_COUNT:     skip_q  <= cfg_data_i;
        CFG_KEYS_IN_USE:    nkeys_q <= cfg_data_i[NKeysW-1:0];
        CFG_KEY_DIRECTIONS: dirs_q  <= cfg_data_i[DirW-1:0];
        default: ;
      endcase
    end
  end

  assign cmp_cfg.keys_in_use    = nkeys_q;
  assign cmp_cfg.key_directions = dirs_q;
  assign lim_sum = SUMW'(keep_q) + SUMW'(skip_q);
  assign lim     = (lim_sum > SUMW'(CAPACITY)) ? LIMW'(CAPACITY) : LIMW'(lim_sum);

  // input unpacking
  assign in_row.key_first  = s_axis_tdata[KeyW-1:0];
  assign in_row.key_second = s_axis_tdata[2*KeyW-1:KeyW];
  assign in_row.key_third  = s_axis_tdata[3*KeyW-1:2*KeyW];
  assign in_row.tag        = s_axis_tdata[DataW-1:3*KeyW];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_take      = !out_valid_q || m_axis_tready;
  assign reject        = |miss_vec;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic p_take, p_valid, n_valid;
    row_t p_row, n_row;
    if (i == 0) begin : g_first
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_row   = in_row;
    end else begin : g_mid
      assign p_take  = takes[i-1];
      assign p_valid = valids[i-1];
      assign p_row   = rows[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_row   = in_row;
    end else begin : g_inner
      assign n_valid = valids[i+1];
      assign n_row   = rows[i+1];
    end
    tkos_cell #(
      .IDX  (i),
      .LIMW (LIMW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cfg_i        (cmp_cfg),
      .lim_i        (lim),
      .in_row_i     (in_row),
      .reject_i     (reject),
      .prev_take_i  (p_take),
      .prev_row_i   (p_row),
      .prev_valid_i (p_valid),
      .next_row_i   (n_row),
      .next_valid_i (n_valid),
      .row_o        (rows[i]),
      .valid_o      (valids[i]),
      .take_o       (takes[i]),
      .miss_o       (miss_vec[i])
    );
    assign valid_vec[i] = valids[i];
  end

  if (CAPACITY > 1) begin : g_v1
    assign v1 = valids[1];
  end else begin : g_v1_none
    assign v1 = 1'b0;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    skip_cnt_d  = skip_cnt_q;
    ctrl.load   = 1'b0;
    ctrl.shift  = 1'b0;
    out_row_d   = out_row_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_LOAD: begin
        ctrl.load = in_acc;
        if (in_acc && s_axis_tlast) begin
          skip_cnt_d = skip_q;
          state_d    = (skip_q == '0) ? ST_EMIT : ST_SKIP;
        end
      end
      ST_SKIP: begin
        ctrl.shift = 1'b1;
        skip_cnt_d = skip_cnt_q - CntW'(1);
        if (skip_cnt_q == CntW'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_take) begin
          out_valid_d = 1'b1;
          if (valids[0]) begin
            ctrl.shift  = 1'b1;
            out_row_d   = rows[0];
            out_last_d  = !v1;
            out_empty_d = 1'b0;
            if (!v1) begin
              state_d = ST_LOAD;
            end
          end else begin
            out_row_d   = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
            state_d     = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      skip_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      skip_cnt_q  <= skip_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_q   <= out_row_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_row_q.key_third, out_row_q.key_second,
                          out_row_q.key_first, out_row_q.tag};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_empty_q;

  // checks
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot((CAPACITY+1)'({1'b0, valid_vec}) + (CAPACITY+1)'(1)))
    else $error("kept rows are not a contiguous prefix of the chain");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("empty result without last flag");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && m_axis_tvalid && !m_axis_tready |=> $stable(valid_vec))
    else $error("chain moved while the output was stalled");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && (state_d == ST_LOAD) |=> (valid_vec == '0))
    else $error("store not empty after the run was drained");

endmodule

@@ tb/sv/top_n_with_offset_selector_test.sv @@
// Self-checking testbench for top_n_with_offset_selector: streams keyed rows under
// varied sort settings and checks every selected row against a behavioural model.
// Depends on tkos_pkg and the top_n_with_offset_selector RTL.
`timescale 1ns / 100ps

module top_n_with_offset_selector_test;
  import tkos_pkg::*;

  localparam int unsigned CAP         = 64;
  localparam int unsigned RANDOM_ROWS = 200;
  localparam int unsigned QUIET_ROWS  = 40;
  localparam int unsigned SETTLE      = 80;
  localparam int unsigned LIMIT       = 400000;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [TagW-1:0]        tag_t;

  typedef struct packed {
    tag_t tag;
    key_t key_first;
    key_t key_second;
    key_t key_third;
    logic last_result;
    logic empty_set;
  } pick_t;

  class selection_scoreboard;
    int unsigned keep_rows = 10;
    int unsigned skip_rows = 0;
    int unsigned key_count = 1;
    bit [DirW-1:0] key_desc = '0;
    key_t kept_key [CAP][3];
    tag_t kept_tag [CAP];
    int unsigned fill = 0;
    pick_t expected_picks [$];
    int unsigned mismatches = 0;

    function void set_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
      case (idx)
        CFG_KEEP_COUNT:     keep_rows = value & 'h7f;
        CFG_SKIP_COUNT:     skip_rows = value & 'h7f;
        CFG_KEYS_IN_USE:    key_count = value & 'h3;
        CFG_KEY_DIRECTIONS: key_desc  = DirW'(value);
        default: ;
      endcase
    endfunction

    // true when the row sorts strictly before kept entry idx
    function bit ranks_before(key_t row [3], int unsigned idx);
      for (int k = 0; k < 3; k++) begin
        if (k < key_count && row[k] != kept_key[idx][k]) begin
          return key_desc[k] ? (row[k] > kept_key[idx][k]) : (row[k] < kept_key[idx][k]);
        end
      end
      return 1'b0;
    endfunction

    function void note_row(key_t row [3], tag_t tag, bit last_row);
      int unsigned lim;
      int unsigned slot;
      int unsigned pos;
      pick_t p;
      lim = skip_rows + keep_rows;
      if (lim > CAP) lim = CAP;
      if (fill > lim) fill = lim;
      if (lim != 0) begin
        if (fill >= lim) begin
          slot = ranks_before(row, lim - 1) ? lim - 1 : CAP;
        end else begin
          slot = fill;
          fill++;
        end
        if (slot != CAP) begin
          pos = 0;
          while (pos < slot && !ranks_before(row, pos)) pos++;
          for (int i = slot; i > pos; i--) begin
            kept_key[i] = kept_key[i-1];
            kept_tag[i] = kept_tag[i-1];
          end
          kept_key[pos] = row;
          kept_tag[pos] = tag;
        end
      end
      if (!last_row) return;
      if (fill > skip_rows) begin
        for (int i = skip_rows; i < fill; i++) begin
          p.tag         = kept_tag[i];
          p.key_first   = kept_key[i][0];
          p.key_second  = kept_key[i][1];
          p.key_third   = kept_key[i][2];
          p.last_result = (i + 1 == fill);
          p.empty_set   = 1'b0;
          expected_picks.insert(expected_picks.size(), p);
        end
      end else begin
        p = '0;
        p.last_result = 1'b1;
        p.empty_set   = 1'b1;
        expected_picks.insert(expected_picks.size(), p);
      end
      fill = 0;
    endfunction

    function void check_pick(logic [DataW-1:0] tdata, logic tlast, logic tuser);
      pick_t got;
      pick_t want;
      got.tag         = tdata[15:0];
      got.key_first   = tdata[47:16];
      got.key_second  = tdata[79:48];
      got.key_third   = tdata[111:80];
      got.last_result = tlast;
      got.empty_set   = tuser;
      if (expected_picks.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: tag %h keys %h %h %h last %b empty %b",
                   got.tag, got.key_first, got.key_second, got.key_third,
                   got.last_result, got.empty_set);
        mismatches++;
        return;
      end
      want = expected_picks.pop_front();
      if (got.tag != want.tag || got.key_first != want.key_first ||
          got.key_second != want.key_second || got.key_third != want.key_third ||
          got.last_result != want.last_result || got.empty_set != want.empty_set) begin
        if (mismatches < 10) begin
          $display("mismatch expected: tag %h keys %h %h %h last %b empty %b",
                   want.tag, want.key_first, want.key_second, want.key_third,
                   want.last_result, want.empty_set);
          $display("         actual:   tag %h keys %h %h %h last %b empty %b",
                   got.tag, got.key_first, got.key_second, got.key_third,
                   got.last_result, got.empty_set);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DataW-1:0]    m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CntW-1:0]     cfg_data_i;

  selection_scoreboard sb;
  bit          quiet = 1'b0;
  bit          open_run = 1'b0;
  int unsigned rows_sent = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  top_n_with_offset_selector #(.CAPACITY(CAP)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // result side: check on handshake, then stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_pick(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= (stall_left == 0);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_row(key_t k1, key_t k2, key_t k3, tag_t tag, bit last_row);
    key_t row [3];
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, k3, k2, k1};
    s_axis_tlast  <= last_row;
    do @(posedge clk_i); while (!s_axis_tready);
    row[0] = k1;
    row[1] = k2;
    row[2] = k3;
    sb.note_row(row, tag, last_row);
    rows_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CntW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, value);
  endtask

  // drain all pending results, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned keep, int unsigned skip, int unsigned keys,
                           int unsigned dirs, bit limit_only);
    write_reg(CFG_KEEP_COUNT, keep);
    write_reg(CFG_SKIP_COUNT, skip);
    if (!limit_only) begin
      write_reg(CFG_KEYS_IN_USE, keys);
      write_reg(CFG_KEY_DIRECTIONS, dirs);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic key_t pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return key_t'(int'($urandom_range(0, 6)) - 3);
    if (r < 8) return key_t'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic int unsigned pick_count(int unsigned near);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 64;
      2: return $urandom_range(0, 64);
      default: return $urandom_range(0, near);
    endcase
  endfunction

  task automatic send_run(int unsigned len, bit close);
    for (int i = 0; i < len; i++)
      send_row(pick_key(), pick_key(), pick_key(), tag_t'($urandom_range(0, 65535)),
               close && (i == len - 1));
  endtask

  initial begin
    int unsigned runs;
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings, extreme key and tag values
    send_row(32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'hffff, 1'b0);
    send_row(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h0000, 1'b0);
    send_row(32'h0, 32'h0, 32'h7fff_ffff, 16'h5a5a, 1'b0);
    send_row(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 16'ha5a5, 1'b0);
    send_row(32'h0, 32'h1, 32'h0, 16'h0001, 1'b1);

    // three keys, mixed directions, full store drops a row ranking after its worst row
    wait_idle();
    configure(2, 1, 3, 3'b101, 1'b0);
    send_row(5, 1, 1, 16'h0011, 1'b0);
    send_row(5, 1, 9, 16'h0012, 1'b0);
    send_row(5, 0, 0, 16'h0013, 1'b0);
    send_row(7, -8, 0, 16'h0014, 1'b0);
    send_row(5, 1, 1, 16'h0015, 1'b1);

    // no keys compared: first rows in arrival order
    wait_idle();
    configure(2, 0, 0, 3'b010, 1'b0);
    send_row(3, 2, 1, 16'h0021, 1'b0);
    send_row(-3, 2, 1, 16'h0022, 1'b0);
    send_row(9, 9, 9, 16'h0023, 1'b0);
    send_row(-9, 0, 0, 16'h0024, 1'b1);

    // zero limit
    wait_idle();
    configure(0, 0, 1, 3'b000, 1'b0);
    send_row(1, 2, 3, 16'h0031, 1'b0);
    send_row(4, 5, 6, 16'h0032, 1'b1);

    // fewer rows than the skip
    wait_idle();
    configure(3, 5, 2, 3'b011, 1'b0);
    send_row(1, 1, 1, 16'h0041, 1'b0);
    send_row(2, 2, 2, 16'h0042, 1'b0);
    send_row(3, 3, 3, 16'h0043, 1'b1);

    // limit lowered in the middle of a run
    wait_idle();
    configure(6, 0, 1, 3'b000, 1'b0);
    for (int i = 0; i < 5; i++)
      send_row(key_t'(10 - i), 0, 0, tag_t'(16'h0050 + i), 1'b0);
    wait_idle();
    configure(2, 0, 1, 3'b000, 1'b1);
    send_row(20, 0, 0, 16'h0056, 1'b1);

    // random phases of well-formed runs, some left open across a limit change
    while (rows_sent < 25 + RANDOM_ROWS) begin
      wait_idle();
      configure(pick_count(12), pick_count(8), $urandom_range(0, 3),
                $urandom_range(0, 7), open_run);
      runs = $urandom_range(1, 3);
      for (int r = 0; r < runs; r++) begin
        if (rows_sent >= 25 + RANDOM_ROWS - QUIET_ROWS) quiet = 1'b1;
        send_run(($urandom_range(0, 6) == 0) ? $urandom_range(50, 90)
                                              : $urandom_range(1, 20), 1'b1);
      end
      open_run = ($urandom_range(0, 5) == 0);
      if (open_run) send_run($urandom_range(1, 10), 1'b0);
    end
    quiet = 1'b1;
    if (open_run) send_run(1, 1'b1);
    s_axis_tvalid <= 1'b0;

    while (sb.expected_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_picks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
